@@ hdl/otb_pkg.sv @@
// shared types and constants for the one-shot / periodic timer bank
// no dependencies
package otb_pkg;

    localparam int IdW = 31;
    localparam logic [IdW-1:0] ID_MAX = 31'h7fff_ffff;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_SET_OS  = 3'd1;
    localparam logic [2:0] MODE_CLR_OS  = 3'd2;
    localparam logic [2:0] MODE_SET_PER = 3'd3;
    localparam logic [2:0] MODE_CLR_PER = 3'd4;

    localparam logic [2:0] KIND_SET      = 3'd0;
    localparam logic [2:0] KIND_CLR      = 3'd1;
    localparam logic [2:0] KIND_FIRE_OS  = 3'd2;
    localparam logic [2:0] KIND_FIRE_PER = 3'd3;
    localparam logic [2:0] KIND_NONE     = 3'd4;

    typedef struct packed {
        logic append;
        logic clear;
        logic scan_rst;
        logic take;
        logic skip;
    } cmd_t;

    typedef struct packed {
        logic           full;
        logic           done;
        logic           fire;
        logic           hit;
        logic [IdW-1:0] tag;
    } sts_t;

endpackage

@@ hdl/oneshot_periodic_timer_bank_unit.sv @@
// sequence: a set or clear word passes through its set or clear state, which loads the result into the output
// register; a tick scans the one-shot table, then the periodic table, then finishes; output stalls hold
// each step; one word in flight at a time. The scan pointer in each table checks one entry per cycle,
// unless a firing must wait for the output register
// reset: async active low clears time, id counters, table fill counts and the controller
module oneshot_periodic_timer_bank_unit #(
    parameter int ONESHOT_SLOTS  = 16,
    parameter int PERIODIC_SLOTS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                mode,
    input  logic [31:0]               now_time,
    input  logic [31:0]               duration,
    input  logic [otb_pkg::IdW-1:0]   target_id,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2:0]                kind,
    output logic [otb_pkg::IdW-1:0]   entry_id,
    output logic                      accepted,
    output logic                      last
);

    logic [31:0]             cur_time_reg;
    logic [31:0]             dur_reg;
    logic [otb_pkg::IdW-1:0] target_reg;
    otb_pkg::cmd_t           cmd_os, cmd_per;
    otb_pkg::sts_t           sts_os, sts_per;
    logic [otb_pkg::IdW-1:0] append_id;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_time_reg <= '0;
        else if (in_valid && in_ready && (mode == otb_pkg::MODE_TICK))
            cur_time_reg <= now_time;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dur_reg    <= duration;
            target_reg <= target_id;
        end
    end

    otb_table #(.SLOTS(ONESHOT_SLOTS), .PERIODIC(1'b0)) u_tab_os (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_os),
        .now       (cur_time_reg),
        .dur       (dur_reg),
        .append_id (append_id),
        .target    (target_reg),
        .sts       (sts_os)
    );

    otb_table #(.SLOTS(PERIODIC_SLOTS), .PERIODIC(1'b1)) u_tab_per (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_per),
        .now       (cur_time_reg),
        .dur       (dur_reg),
        .append_id (append_id),
        .target    (target_reg),
        .sts       (sts_per)
    );

    otb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .target    (target_reg),
        .sts_os    (sts_os),
        .sts_per   (sts_per),
        .cmd_os    (cmd_os),
        .cmd_per   (cmd_per),
        .append_id (append_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .entry_id  (entry_id),
        .accepted  (accepted),
        .last      (last)
    );

`ifndef SYNTHESIS
    a_acc_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> (kind == otb_pkg::KIND_SET || kind == otb_pkg::KIND_CLR))
        else $error("accepted flag on a fired or empty result");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == otb_pkg::KIND_NONE) |-> last && (entry_id == '0))
        else $error("empty tick result must be last with id zero");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (mode == otb_pkg::MODE_TICK) |=> !in_ready)
        else $error("tick must occupy the controller");
`endif

endmodule

@@ hdl/otb_table.sv @@
// one timer table kept as a list in ascending id order, with a scan pointer
// depends on otb_pkg
module otb_table #(
    parameter int SLOTS    = 16,
    parameter bit PERIODIC = 1'b0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  otb_pkg::cmd_t             cmd,
    input  logic [31:0]               now,
    input  logic [31:0]               dur,
    input  logic [otb_pkg::IdW-1:0]   append_id,
    input  logic [otb_pkg::IdW-1:0]   target,
    output otb_pkg::sts_t             sts
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [31:0]             start_q [SLOTS];
    logic [31:0]             dur_q   [SLOTS];
    logic [otb_pkg::IdW-1:0] tag_q   [SLOTS];

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] ptr_a;
    logic [AW-1:0] hit_idx;
    logic          hit;
    logic [AW-1:0] rm_pos;
    logic          rm_en;
    logic          adv_en;
    logic [31:0]   due;

    assign ptr_a = ptr_reg[AW-1:0];
    assign due   = start_q[ptr_a] + dur_q[ptr_a];

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if ((CW'(k) < cnt_reg) && (tag_q[k] == target))
            begin
                hit     = 1'b1;
                hit_idx = AW'(k);
            end
        end
    end

    assign rm_en  = (cmd.clear && hit) || (cmd.take && !PERIODIC);
    assign rm_pos = cmd.clear ? hit_idx : ptr_a;
    assign adv_en = cmd.take && PERIODIC;

    always_comb
    begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (cmd.append)
            cnt_next = cnt_reg + 1'b1;
        else if (rm_en)
            cnt_next = cnt_reg - 1'b1;
        if (cmd.scan_rst)
            ptr_next = '0;
        else if (cmd.skip || adv_en)
            ptr_next = ptr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    // removal closes the gap so the list stays in id order
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            if (rm_en && (AW'(k) >= rm_pos) && (k < SLOTS - 1))
            begin
                start_q[k] <= start_q[k+1];
                dur_q[k]   <= dur_q[k+1];
                tag_q[k]   <= tag_q[k+1];
            end
            if (cmd.append && (CW'(k) == cnt_reg))
            begin
                start_q[k] <= now;
                dur_q[k]   <= dur;
                tag_q[k]   <= append_id;
            end
            if (adv_en && (AW'(k) == ptr_a))
                start_q[k] <= due;
        end
    end

    assign sts.full = (cnt_reg == CW'(SLOTS));
    assign sts.done = (ptr_reg >= cnt_reg);
    assign sts.fire = (ptr_reg < cnt_reg) && (due < now);
    assign sts.hit  = hit;
    assign sts.tag  = tag_q[ptr_a];

endmodule

@@ hdl/otb_ctrl.sv @@
// controller: request sequencing, id counters, pending result and output register
// depends on otb_pkg
module otb_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                mode,
    input  logic [otb_pkg::IdW-1:0]   target,
    input  otb_pkg::sts_t             sts_os,
    input  otb_pkg::sts_t             sts_per,
    output otb_pkg::cmd_t             cmd_os,
    output otb_pkg::cmd_t             cmd_per,
    output logic [otb_pkg::IdW-1:0]   append_id,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2:0]                kind,
    output logic [otb_pkg::IdW-1:0]   entry_id,
    output logic                      accepted,
    output logic                      last
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SET_OS, ST_SET_PER, ST_CLR_OS, ST_CLR_PER,
        ST_SCAN_OS, ST_SCAN_PER, ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [otb_pkg::IdW-1:0] ctr_os_reg, ctr_per_reg;
    logic                    pend_reg;
    logic [2:0]              pend_kind_reg;
    logic [otb_pkg::IdW-1:0] pend_id_reg;
    logic                    can_emit;
    logic                    take_ok;
    logic                    tick_acc;
    logic                    set_os_ok, set_per_ok;
    logic                    emit_now;

    assign in_ready   = (state_reg == ST_IDLE);
    assign can_emit   = !out_valid || out_ready;
    assign take_ok    = !pend_reg || can_emit;
    assign tick_acc   = in_valid && in_ready && (mode == otb_pkg::MODE_TICK);
    assign set_os_ok  = !sts_os.full && (ctr_os_reg < otb_pkg::ID_MAX);
    assign set_per_ok = !sts_per.full && (ctr_per_reg < otb_pkg::ID_MAX);
    assign append_id  = (state_reg == ST_SET_OS) ? ctr_os_reg + 1'b1 : ctr_per_reg + 1'b1;

    always_comb
    begin
        cmd_os  = '0;
        cmd_per = '0;
        cmd_os.scan_rst  = tick_acc;
        cmd_per.scan_rst = tick_acc;
        case (state_reg)
            ST_SET_OS:   cmd_os.append  = can_emit && set_os_ok;
            ST_SET_PER:  cmd_per.append = can_emit && set_per_ok;
            ST_CLR_OS:   cmd_os.clear   = can_emit;
            ST_CLR_PER:  cmd_per.clear  = can_emit;
            ST_SCAN_OS:
            begin
                cmd_os.take = !sts_os.done && sts_os.fire && take_ok;
                cmd_os.skip = !sts_os.done && !sts_os.fire;
            end
            ST_SCAN_PER:
            begin
                cmd_per.take = !sts_per.done && sts_per.fire && take_ok;
                cmd_per.skip = !sts_per.done && !sts_per.fire;
            end
            default: ;
        endcase
    end

    // a new word enters the output register this cycle
    always_comb
    begin
        case (state_reg)
            ST_SET_OS, ST_SET_PER, ST_CLR_OS, ST_CLR_PER, ST_FINISH:
                emit_now = can_emit;
            ST_SCAN_OS:  emit_now = cmd_os.take && pend_reg;
            ST_SCAN_PER: emit_now = cmd_per.take && pend_reg;
            default:     emit_now = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ctr_os_reg    <= '0;
            ctr_per_reg   <= '0;
            pend_reg      <= 1'b0;
            pend_kind_reg <= otb_pkg::KIND_NONE;
            pend_id_reg   <= '0;
            out_valid     <= 1'b0;
            kind          <= otb_pkg::KIND_NONE;
            entry_id      <= '0;
            accepted      <= 1'b0;
            last          <= 1'b0;
        end
        else
        begin
            if (emit_now)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (mode)
                            otb_pkg::MODE_TICK:
                            begin
                                pend_reg  <= 1'b0;
                                state_reg <= ST_SCAN_OS;
                            end
                            otb_pkg::MODE_SET_OS:  state_reg <= ST_SET_OS;
                            otb_pkg::MODE_CLR_OS:  state_reg <= ST_CLR_OS;
                            otb_pkg::MODE_SET_PER: state_reg <= ST_SET_PER;
                            otb_pkg::MODE_CLR_PER: state_reg <= ST_CLR_PER;
                            default:               state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SET_OS, ST_SET_PER:
                begin
                    if (can_emit)
                    begin
                        kind      <= otb_pkg::KIND_SET;
                        last      <= 1'b1;
                        accepted  <= cmd_os.append || cmd_per.append;
                        entry_id  <= (cmd_os.append || cmd_per.append) ? append_id : '0;
                        if (cmd_os.append)
                            ctr_os_reg <= append_id;
                        if (cmd_per.append)
                            ctr_per_reg <= append_id;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_CLR_OS, ST_CLR_PER:
                begin
                    if (can_emit)
                    begin
                        kind      <= otb_pkg::KIND_CLR;
                        last      <= 1'b1;
                        entry_id  <= target;
                        accepted  <= (state_reg == ST_CLR_OS) ? sts_os.hit : sts_per.hit;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SCAN_OS, ST_SCAN_PER:
                begin
                    if (((state_reg == ST_SCAN_OS) && sts_os.done) ||
                        ((state_reg == ST_SCAN_PER) && sts_per.done))
                    begin
                        state_reg <= (state_reg == ST_SCAN_OS) ? ST_SCAN_PER : ST_FINISH;
                    end
                    else if (cmd_os.take || cmd_per.take)
                    begin
                        // older firing goes out, newest one waits to learn if it is last
                        if (pend_reg)
                        begin
                            kind      <= pend_kind_reg;
                            entry_id  <= pend_id_reg;
                            accepted  <= 1'b0;
                            last      <= 1'b0;
                        end
                        pend_reg <= 1'b1;
                        if (cmd_os.take)
                        begin
                            pend_kind_reg <= otb_pkg::KIND_FIRE_OS;
                            pend_id_reg   <= sts_os.tag;
                        end
                        else
                        begin
                            pend_kind_reg <= otb_pkg::KIND_FIRE_PER;
                            pend_id_reg   <= sts_per.tag;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (can_emit)
                    begin
                        accepted  <= 1'b0;
                        last      <= 1'b1;
                        kind      <= pend_reg ? pend_kind_reg : otb_pkg::KIND_NONE;
                        entry_id  <= pend_reg ? pend_id_reg : '0;
                        pend_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the one-shot / periodic timer bank
// depends on otb_pkg and oneshot_periodic_timer_bank_unit
module testbench;

    localparam int IdW = otb_pkg::IdW;
    localparam int OS_SLOTS  = 16;
    localparam int PER_SLOTS = 16;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]     mode;
        logic [31:0]    now_time;
        logic [31:0]    duration;
        logic [IdW-1:0] target_id;
    } request_t;

    typedef struct packed {
        logic [2:0]     kind;
        logic [IdW-1:0] entry_id;
        logic           accepted;
        logic           last;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] mode = '0;
    logic [31:0] now_time = '0;
    logic [31:0] duration = '0;
    logic [IdW-1:0] target_id = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] kind;
    logic [IdW-1:0] entry_id;
    logic accepted;
    logic last;

    oneshot_periodic_timer_bank_unit #(
        .ONESHOT_SLOTS (OS_SLOTS),
        .PERIODIC_SLOTS(PER_SLOTS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .now_time (now_time),
        .duration (duration),
        .target_id(target_id),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind     (kind),
        .entry_id (entry_id),
        .accepted (accepted),
        .last     (last)
    );

    always #4 clk = ~clk;

    // timer state mirrored in the predictor
    logic [31:0]    tmr_now;
    logic [IdW-1:0] os_ctr, per_ctr;
    logic           os_vld [OS_SLOTS];
    logic [31:0]    os_start [OS_SLOTS];
    logic [31:0]    os_dur [OS_SLOTS];
    logic [IdW-1:0] os_id [OS_SLOTS];
    logic           per_vld [PER_SLOTS];
    logic [31:0]    per_start [PER_SLOTS];
    logic [31:0]    per_dur [PER_SLOTS];
    logic [IdW-1:0] per_id [PER_SLOTS];

    request_t pending_words[$];
    reply_t   expected_replies[$];
    int       error_count = 0;

    bit rx_hold = 1'b0;
    bit tx_pause = 1'b0;
    bit calm = 1'b0;
    int stuck_cycles = 0;

    // acceptance seen at the rising edge, consumed by the driver at the next falling edge
    logic in_ready_q = 1'b0;

    task automatic report_mismatch(input string what, input reply_t got, input reply_t exp);
        $display("error: %s got kind %0d id %0d acc %0d last %0d,", what,
                 got.kind, got.entry_id, got.accepted, got.last,
                 " exp kind %0d id %0d acc %0d last %0d",
                 exp.kind, exp.entry_id, exp.accepted, exp.last);
        error_count++;
    endtask

    function automatic reply_t mk(input logic [2:0] k, input logic [IdW-1:0] id,
                                  input logic acc);
        reply_t r;
        r.kind = k;
        r.entry_id = id;
        r.accepted = acc;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_timer_bank(input request_t w);
        reply_t res[$];
        int slot;
        bit found;
        logic [IdW-1:0] best;
        int pick;
        bit done_os [OS_SLOTS];
        bit done_per [PER_SLOTS];
        slot = -1;
        found = 1'b0;
        case (w.mode)
            otb_pkg::MODE_TICK: begin
                tmr_now = w.now_time;
                foreach (done_os[i]) done_os[i] = 1'b0;
                foreach (done_per[i]) done_per[i] = 1'b0;
                // one-shot table in id order
                forever begin
                    pick = -1;
                    for (int i = 0; i < OS_SLOTS; i++)
                        if (os_vld[i] && !done_os[i] && (pick < 0 || os_id[i] < best)) begin
                            pick = i;
                            best = os_id[i];
                        end
                    if (pick < 0) break;
                    done_os[pick] = 1'b1;
                    if (os_start[pick] + os_dur[pick] < tmr_now) begin
                        res.push_back(mk(otb_pkg::KIND_FIRE_OS, os_id[pick], 1'b0));
                        os_vld[pick] = 1'b0;
                    end
                end
                forever begin
                    pick = -1;
                    for (int i = 0; i < PER_SLOTS; i++)
                        if (per_vld[i] && !done_per[i] && (pick < 0 || per_id[i] < best)) begin
                            pick = i;
                            best = per_id[i];
                        end
                    if (pick < 0) break;
                    done_per[pick] = 1'b1;
                    if (per_start[pick] + per_dur[pick] < tmr_now) begin
                        res.push_back(mk(otb_pkg::KIND_FIRE_PER, per_id[pick], 1'b0));
                        per_start[pick] = per_start[pick] + per_dur[pick];
                    end
                end
                if (res.size() == 0) res.push_back(mk(otb_pkg::KIND_NONE, '0, 1'b0));
            end
            otb_pkg::MODE_SET_OS: begin
                for (int i = OS_SLOTS - 1; i >= 0; i--) if (!os_vld[i]) slot = i;
                if (slot < 0 || os_ctr >= otb_pkg::ID_MAX) begin
                    res.push_back(mk(otb_pkg::KIND_SET, '0, 1'b0));
                end else begin
                    os_ctr = os_ctr + 1'b1;
                    os_vld[slot] = 1'b1;
                    os_id[slot] = os_ctr;
                    os_start[slot] = tmr_now;
                    os_dur[slot] = w.duration;
                    res.push_back(mk(otb_pkg::KIND_SET, os_ctr, 1'b1));
                end
            end
            otb_pkg::MODE_SET_PER: begin
                for (int i = PER_SLOTS - 1; i >= 0; i--) if (!per_vld[i]) slot = i;
                if (slot < 0 || per_ctr >= otb_pkg::ID_MAX) begin
                    res.push_back(mk(otb_pkg::KIND_SET, '0, 1'b0));
                end else begin
                    per_ctr = per_ctr + 1'b1;
                    per_vld[slot] = 1'b1;
                    per_id[slot] = per_ctr;
                    per_start[slot] = tmr_now;
                    per_dur[slot] = w.duration;
                    res.push_back(mk(otb_pkg::KIND_SET, per_ctr, 1'b1));
                end
            end
            otb_pkg::MODE_CLR_OS: begin
                for (int i = 0; i < OS_SLOTS; i++)
                    if (os_vld[i] && os_id[i] == w.target_id) begin
                        os_vld[i] = 1'b0;
                        found = 1'b1;
                    end
                res.push_back(mk(otb_pkg::KIND_CLR, w.target_id, found));
            end
            otb_pkg::MODE_CLR_PER: begin
                for (int i = 0; i < PER_SLOTS; i++)
                    if (per_vld[i] && per_id[i] == w.target_id) begin
                        per_vld[i] = 1'b0;
                        found = 1'b1;
                    end
                res.push_back(mk(otb_pkg::KIND_CLR, w.target_id, found));
            end
            default: ;
        endcase
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        foreach (res[i]) expected_replies.push_back(res[i]);
    endtask

    function automatic request_t word(input logic [2:0] m, input logic [31:0] t,
                                      input logic [31:0] d, input logic [IdW-1:0] id);
        request_t w;
        w.mode = m;
        w.now_time = t;
        w.duration = d;
        w.target_id = id;
        return w;
    endfunction

    function automatic logic [31:0] rand_dur();
        case ($urandom_range(0, 5))
            0: return 32'hffff_ffff;
            1: return 32'd0;
            2: return $urandom();
            default: return $urandom_range(1, 400);
        endcase
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_ready_q) begin
                if (pending_words.size() > 0 && !tx_pause && (calm || $urandom_range(0, 99) >= 37))
                begin
                    request_t w;
                    w = pending_words.pop_front();
                    in_valid <= 1'b1;
                    mode <= w.mode;
                    now_time <= w.now_time;
                    duration <= w.duration;
                    target_id <= w.target_id;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= !rx_hold && (calm || $urandom_range(0, 99) >= 37);
        end
    end

    // monitor: everything sampled at the rising edge
    always @(posedge clk) begin
        reply_t got, exp;
        in_ready_q <= in_valid && in_ready;
        if (rst_n) begin
            if (in_valid && in_ready) predict_timer_bank({mode, now_time, duration, target_id});
            if (out_valid && out_ready) begin
                got = {kind, entry_id, accepted, last};
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected word", got, got);
                end else begin
                    exp = expected_replies.pop_front();
                    if (got !== exp) report_mismatch("field mismatch", got, exp);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
            else stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // queue a word for the driver
    task automatic push_word(input request_t w);
        pending_words.push_back(w);
    endtask

    task automatic wait_sent();
        while (pending_words.size() > 0)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_replies.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [IdW-1:0] rand_target(input logic [IdW-1:0] hi);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return otb_pkg::ID_MAX;
            2: return IdW'($urandom()) & otb_pkg::ID_MAX;
            default: return IdW'($urandom_range(1, hi + 2));
        endcase
    endfunction

    initial begin
        logic [31:0] t;
        tmr_now = '0;
        os_ctr = '0;
        per_ctr = '0;
        foreach (os_vld[i]) os_vld[i] = 1'b0;
        foreach (per_vld[i]) per_vld[i] = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, empty tick, clears that miss, fill a table past full
        push_word(word(otb_pkg::MODE_TICK, 32'd0, '0, '0));
        push_word(word(otb_pkg::MODE_CLR_OS, '0, '0, '0));
        push_word(word(otb_pkg::MODE_CLR_PER, '0, '0, otb_pkg::ID_MAX));
        push_word(word(3'd5, $urandom(), $urandom(), otb_pkg::ID_MAX));
        push_word(word(3'd7, '0, '0, '0));
        push_word(word(otb_pkg::MODE_SET_OS, '0, 32'hffff_ffff, '0));
        push_word(word(otb_pkg::MODE_SET_OS, '0, 32'd0, '0));
        push_word(word(otb_pkg::MODE_SET_PER, '0, 32'd5, '0));
        push_word(word(otb_pkg::MODE_SET_PER, '0, 32'd0, '0));
        push_word(word(otb_pkg::MODE_TICK, 32'd3, '0, '0));
        push_word(word(otb_pkg::MODE_TICK, 32'd20, '0, '0));
        push_word(word(otb_pkg::MODE_CLR_OS, '0, '0, 31'd1));
        push_word(word(otb_pkg::MODE_CLR_PER, '0, '0, 31'd1));
        push_word(word(otb_pkg::MODE_CLR_PER, '0, '0, 31'd2));
        push_word(word(otb_pkg::MODE_TICK, 32'hffff_ffff, '0, '0));
        for (int i = 0; i < 18; i++)
            push_word(word(otb_pkg::MODE_SET_OS, '0, 32'hffff_fff0, '0));
        push_word(word(otb_pkg::MODE_SET_PER, '0, 32'h8000_0000, '0));
        push_word(word(otb_pkg::MODE_TICK, 32'h0000_0000, '0, '0));
        calm = 1'b1;
        wait_drained();
        calm = 1'b0;

        // receiver holds off while sender keeps offering
        rx_hold = 1'b1;
        for (int i = 0; i < 10; i++) begin
            push_word(word(otb_pkg::MODE_SET_PER, '0, $urandom_range(1, 50), '0));
            push_word(word(otb_pkg::MODE_TICK, $urandom_range(0, 2000), '0, '0));
        end
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
        wait_drained();

        // random part: sets, ticks with moving time, clears of plausible ids and unused modes
        t = '0;
        for (int n = 0; n < 250; n++) begin
            if (n == 120) begin
                wait_sent();
                calm = 1'b1;
            end
            if (n == 170) begin
                wait_sent();
                calm = 1'b0;
            end
            if (n == 200) begin
                wait_sent();
                tx_pause = 1'b1;
                wait_drained();
                tx_pause = 1'b0;
            end
            case ($urandom_range(0, 9))
                0, 1: push_word(word(otb_pkg::MODE_SET_OS, $urandom(), rand_dur(),
                                     IdW'($urandom())));
                2, 3: push_word(word(otb_pkg::MODE_SET_PER, $urandom(), rand_dur(),
                                     IdW'($urandom())));
                4: push_word(word(otb_pkg::MODE_CLR_OS, $urandom(), $urandom(),
                                  rand_target(31'd60)));
                5: push_word(word(otb_pkg::MODE_CLR_PER, $urandom(), $urandom(),
                                  rand_target(31'd60)));
                6: push_word(word(3'($urandom_range(5, 7)), $urandom(), $urandom(),
                                  IdW'($urandom())));
                default: begin
                    t = ($urandom_range(0, 9) == 0) ? $urandom() : t + $urandom_range(0, 300);
                    push_word(word(otb_pkg::MODE_TICK, t, $urandom(), IdW'($urandom())));
                end
            endcase
        end
        wait_drained();
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
